// File: src/lbof_pkg.sv
`default_nettype none

package lbof_pkg;

    localparam int unsigned CLASS_W    = 5;
    localparam int unsigned CODE_W     = 6;
    localparam int unsigned CLASS_COUNT = 27;

    localparam logic [CLASS_W-1:0] CLASS_NONE = 5'd0;
    localparam logic [CLASS_W-1:0] CLASS_AL   = 5'd12;
    localparam logic [CLASS_W-1:0] CLASS_WJ   = 5'd21;

    localparam logic [CODE_W-1:0] CODE_MANDATORY = 6'd27;
    localparam logic [CODE_W-1:0] CODE_SPACE     = 6'd32;
    localparam logic [CODE_W-1:0] CODE_AL        = 6'd12;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0a;

    typedef enum logic [1:0] {
        PA_D,
        PA_I,
        PA_P
    } pair_act_t;

    typedef struct packed {
        logic                seg_open;
        logic [CLASS_W-1:0]  cur_class;
        logic                after_space;
    } lbof_state_t;

    typedef struct packed {
        logic                seg_start;
        logic                seg_closed;
        logic [CLASS_W-1:0]  byte_class;
    } lbof_result_t;

    localparam logic [CODE_W-1:0] ASCII_CLASS [128] = '{
        20, 20, 20, 20, 20, 20, 20, 20, 20, 16, 27, 27, 27, 12, 20, 20,
        20, 20, 20, 20, 20, 20, 20, 20, 20, 20, 20, 20, 20, 20, 20, 20,
        32, 6, 3, 12, 9, 10, 12, 3, 0, 2, 12, 9, 7, 15, 8, 7,
        11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 8, 8, 12, 12, 12, 6,
        12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12,
        12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 0, 9, 2, 12, 12,
        12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12,
        12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 0, 16, 1, 12, 20
    };

    localparam pair_act_t PAIR_ACTION [CLASS_COUNT][CLASS_COUNT] = '{
        '{PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P,
          PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P, PA_P},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_P, PA_P, PA_P, PA_P, PA_I, PA_I, PA_D, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_P, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I,
          PA_I, PA_I, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I},
        '{PA_I, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I,
          PA_I, PA_I, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_I, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_I, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_I, PA_I,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I},
        '{PA_I, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_I, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_I, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_I, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_D, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_D, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_I, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I,
          PA_I, PA_I, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D,
          PA_D, PA_I, PA_I, PA_D, PA_P, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D,
          PA_D, PA_D, PA_D, PA_D, PA_D, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_D, PA_I, PA_I, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_D},
        '{PA_I, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I,
          PA_I, PA_I, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_I},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_I, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_I, PA_I},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_I, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_I},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_I, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_I, PA_I, PA_I, PA_I, PA_D},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_I, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_I, PA_I},
        '{PA_D, PA_P, PA_P, PA_I, PA_I, PA_I, PA_P, PA_P, PA_P, PA_D, PA_I, PA_D, PA_D, PA_D,
          PA_I, PA_I, PA_I, PA_D, PA_D, PA_P, PA_P, PA_P, PA_D, PA_D, PA_D, PA_D, PA_I}
    };

endpackage

`default_nettype wire

// File: src/lbof_classify.sv
`default_nettype none

module lbof_classify
    import lbof_pkg::*;
(
    input  wire logic [7:0]        text_byte,
    output logic      [CODE_W-1:0] code
);

    always_comb begin
        if (text_byte[7]) begin
            code = CODE_AL;
        end else if (text_byte == NEWLINE_BYTE) begin
            code = CODE_MANDATORY;
        end else begin
            code = ASCII_CLASS[text_byte[6:0]];
        end
    end

endmodule

`default_nettype wire

// File: src/lbof_step.sv
`default_nettype none

module lbof_step
    import lbof_pkg::*;
(
    input  wire logic [CODE_W-1:0] code,
    input  wire logic              text_start,
    input  wire lbof_state_t       state,
    output lbof_state_t            state_next,
    output lbof_result_t           result
);

    logic [CLASS_W-1:0] left;
    logic [CLASS_W-1:0] right;
    pair_act_t          act;

    always_comb begin
        left  = (state.cur_class < CLASS_W'(CLASS_COUNT)) ? state.cur_class : CLASS_AL;
        right = (code < CODE_W'(CLASS_COUNT)) ? code[CLASS_W-1:0] : CLASS_AL;
        act   = PAIR_ACTION[left][right];
    end

    always_comb begin
        state_next = state;
        result     = '0;
        if (text_start || !state.seg_open) begin
            result.seg_start = 1'b1;
            if (code == CODE_MANDATORY) begin
                result.seg_closed   = 1'b1;
                result.byte_class   = CLASS_NONE;
                state_next.seg_open = 1'b0;
            end else begin
                // a leading space counts as word joiner
                state_next.seg_open    = 1'b1;
                state_next.cur_class   = (code == CODE_SPACE) ? CLASS_WJ : code[CLASS_W-1:0];
                state_next.after_space = 1'b0;
                result.byte_class      = state_next.cur_class;
            end
        end else if (code == CODE_MANDATORY) begin
            result.seg_closed   = 1'b1;
            result.byte_class   = CLASS_NONE;
            state_next.seg_open = 1'b0;
        end else if (code == CODE_SPACE) begin
            state_next.after_space = 1'b1;
            result.byte_class      = CLASS_WJ;
        end else begin
            result.seg_start       = (act == PA_D) || ((act == PA_I) && state.after_space);
            state_next.cur_class   = right;
            state_next.after_space = 1'b0;
            result.byte_class      = right;
        end
    end

endmodule

`default_nettype wire

// File: src/line_break_opportunity_finder.sv
// Marks line-break opportunities in a byte stream using the ASCII class table and the
// 27 by 27 pair table of simplified Unicode line breaking. Each accepted byte yields one
// result: segment_start (a break lies just before the byte), segment_closed (a newline,
// vertical tab or form feed ends the segment after it) and the byte's pair class.
// One byte per cycle while m_ready is high; each byte goes through an input register,
// then the class and pair-table lookup into the result register. A byte with text_start
// high begins a new text and always opens a segment.
`default_nettype none

module line_break_opportunity_finder
    import lbof_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_text_byte,
    input  wire logic               s_text_start,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_segment_start,
    output logic                    m_segment_closed,
    output logic      [CLASS_W-1:0] m_byte_class
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_start_reg;
    logic         out_valid_reg, out_valid_next;
    lbof_result_t out_reg;
    lbof_state_t  state_reg;
    lbof_state_t  state_next;
    lbof_result_t result;
    logic [CODE_W-1:0] code;
    logic         out_free;
    logic         advance;
    logic         s_xfer;

    lbof_classify u_classify (
        .text_byte (in_byte_reg),
        .code      (code)
    );

    lbof_step u_step (
        .code       (code),
        .text_start (in_start_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        advance  = in_valid_reg && out_free;
        s_ready  = !in_valid_reg || out_free;
        s_xfer   = s_valid && s_ready;

        in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg  <= s_text_byte;
            in_start_reg <= s_text_start;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_segment_start  = out_reg.seg_start;
    assign m_segment_closed = out_reg.seg_closed;
    assign m_byte_class     = out_reg.byte_class;

endmodule

`default_nettype wire

// File: src/lbof_checker.sv
`default_nettype none

module lbof_checker
    import lbof_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic               m_segment_start,
    input  wire logic               m_segment_closed,
    input  wire logic [CLASS_W-1:0] m_byte_class
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // mandatory break bytes report class zero
    a_closed_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_segment_closed |-> m_byte_class == CLASS_NONE)
        else $error("closed segment with nonzero class");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_class < CLASS_W'(CLASS_COUNT))
        else $error("class out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_segment_start)
            && $stable(m_segment_closed) && $stable(m_byte_class))
        else $error("stalled result changed");

    // input side can take a transfer whenever the output is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind line_break_opportunity_finder lbof_checker u_lbof_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_segment_start  (m_segment_start),
    .m_segment_closed (m_segment_closed),
    .m_byte_class     (m_byte_class)
);

`default_nettype wire

// File: bench/line_break_opportunity_finder_tb.sv
module line_break_opportunity_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbof_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned RANDOM_ITEMS  = 1600;
    localparam int unsigned MAX_REPORTS   = 10;

    localparam logic [7:0] TAB_BYTE = 8'h09;
    localparam logic [7:0] VT_BYTE  = 8'h0b;
    localparam logic [7:0] FF_BYTE  = 8'h0c;
    localparam logic [7:0] CR_BYTE  = 8'h0d;
    localparam logic [7:0] DEL_BYTE = 8'h7f;

    localparam logic [8*31-1:0] PUNCT = "!\"#$%&'()*+,-./:;<=>?@[\\]^_{|}~";

    typedef enum logic [CLASS_W-1:0] {
        LB_OP, LB_CL, LB_CP, LB_QU, LB_GL, LB_NS, LB_EX, LB_SY, LB_IS,
        LB_PR, LB_PO, LB_NU, LB_AL, LB_ID, LB_IN, LB_HY, LB_BA, LB_BB,
        LB_B2, LB_ZW, LB_CM, LB_WJ, LB_H2, LB_H3, LB_JL, LB_JV, LB_JT
    } lb_class_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN,
        RDY_LONG_STALL
    } ready_mode_t;

    typedef struct packed {
        logic       drain;
        logic       text_start;
        logic [7:0] text_byte;
    } text_item_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_text_byte;
    logic               s_text_start;
    logic               m_valid;
    logic               m_ready;
    logic               m_segment_start;
    logic               m_segment_closed;
    logic [CLASS_W-1:0] m_byte_class;

    text_item_t   pending_text[$];
    lbof_result_t expected_marks[$];

    logic               lb_seg_open    = 1'b0;
    logic [CLASS_W-1:0] lb_cur_class   = '0;
    logic               lb_after_space = 1'b0;

    logic        in_fire = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    ready_mode_t ready_mode = RDY_ALWAYS;
    int unsigned ready_span = 0;
    int unsigned stall_left = 0;
    logic [7:0]  ready_pattern = 8'hff;

    line_break_opportunity_finder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_text_start     (s_text_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_segment_start  (m_segment_start),
        .m_segment_closed (m_segment_closed),
        .m_byte_class     (m_byte_class)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] byte_code(input logic [7:0] b);
        lb_class_t c;
        if (b[7])
            return CODE_AL;
        if (b == NEWLINE_BYTE || b == VT_BYTE || b == FF_BYTE)
            return CODE_MANDATORY;
        if (b == " ")
            return CODE_SPACE;
        c = LB_AL;
        if (b < 8'h20 || b == DEL_BYTE)
            c = LB_CM;
        if (b >= "0" && b <= "9")
            c = LB_NU;
        case (b)
            TAB_BYTE, "|":      c = LB_BA;
            CR_BYTE:            c = LB_AL;
            "!", "?":           c = LB_EX;
            "\"", "'":          c = LB_QU;
            "$", "+", "\\":     c = LB_PR;
            "%":                c = LB_PO;
            "(", "[", "{":      c = LB_OP;
            ")", "]":           c = LB_CP;
            "}":                c = LB_CL;
            ",", "/":           c = LB_SY;
            ".", ":", ";":      c = LB_IS;
            "-":                c = LB_HY;
            default:            ;
        endcase
        return {1'b0, c};
    endfunction

    // one row per left class, one letter per right class
    function automatic logic [8*CLASS_COUNT-1:0] pair_row(input logic [CLASS_W-1:0] left);
        case (left)
            LB_OP:   return "PPPPPPPPPPPPPPPPPPPPPPPPPPP";
            LB_CL:   return "DPPIIPPPPIIDDDDIIDDPPPDDDDD";
            LB_CP:   return "DPPIIPPPPIIIIDDIIDDPPPDDDDD";
            LB_QU:   return "PPPIIIPPPIIIIIIIIIIPPPIIIII";
            LB_GL:   return "IPPIIIPPPIIIIIIIIIIPPPIIIII";
            LB_NS:   return "DPPIIIPPPDDDDDDIIDDPPPDDDDD";
            LB_EX:   return "DPPIIIPPPDDDDDDIIDDPPPDDDDD";
            LB_SY:   return "DPPIIIPPPDDIDDDIIDDPPPDDDDD";
            LB_IS:   return "DPPIIIPPPDDIIDDIIDDPPPDDDDD";
            LB_PR:   return "IPPIIIPPPDDIIIDIIDDPPPIIIII";
            LB_PO:   return "IPPIIIPPPDDIIDDIIDDPPPDDDDD";
            LB_NU:   return "DPPIIIPPPIIIIDIIIDDPPPDDDDD";
            LB_AL:   return "DPPIIIPPPDDIIDIIIDDPPPDDDDD";
            LB_ID:   return "DPPIIIPPPDIDDDIIIDDPPPDDDDD";
            LB_IN:   return "DPPIIIPPPDDDDDIIIDDPPPDDDDD";
            LB_HY:   return "DPPIDIPPPDDIDDDIIDDPPPDDDDD";
            LB_BA:   return "DPPIDIPPPDDDDDDIIDDPPPDDDDD";
            LB_BB:   return "IPPIIIPPPIIIIIIIIIIPPPIIIII";
            LB_B2:   return "DPPIIIPPPDDDDDDIIDPPPPDDDDD";
            LB_ZW:   return "DDDDDDDDDDDDDDDDDDDPDDDDDDD";
            LB_CM:   return "DPPIIIPPPDDIIDIIIDDPPPDDDDD";
            LB_WJ:   return "IPPIIIPPPIIIIIIIIIIPPPIIIII";
            LB_H2:   return "DPPIIIPPPDIDDDIIIDDPPPDDDII";
            LB_H3:   return "DPPIIIPPPDIDDDIIIDDPPPDDDDI";
            LB_JL:   return "DPPIIIPPPDIDDDIIIDDPPPIIIID";
            LB_JV:   return "DPPIIIPPPDIDDDIIIDDPPPDDDII";
            default: return "DPPIIIPPPDIDDDIIIDDPPPDDDDI";
        endcase
    endfunction

    function automatic lbof_result_t predict_marks(input logic [7:0] b, input logic first);
        lbof_result_t r;
        logic [CODE_W-1:0] code;
        logic [CLASS_W-1:0] left;
        logic [CLASS_W-1:0] right;
        logic [8*CLASS_COUNT-1:0] row;
        logic [7:0] act;
        code = byte_code(b);
        r = '0;
        if (first || !lb_seg_open) begin
            r.seg_start = 1'b1;
            if (code == CODE_MANDATORY) begin
                r.seg_closed = 1'b1;
                lb_seg_open = 1'b0;
            end else begin
                left = (code == CODE_SPACE) ? CLASS_WJ : code[CLASS_W-1:0];
                lb_seg_open = 1'b1;
                lb_cur_class = left;
                lb_after_space = 1'b0;
                r.byte_class = left;
            end
        end else if (code == CODE_MANDATORY) begin
            r.seg_closed = 1'b1;
            lb_seg_open = 1'b0;
        end else if (code == CODE_SPACE) begin
            lb_after_space = 1'b1;
            r.byte_class = CLASS_WJ;
        end else begin
            left = (lb_cur_class < CLASS_COUNT) ? lb_cur_class : CLASS_AL;
            right = (code < CLASS_COUNT) ? code[CLASS_W-1:0] : CLASS_AL;
            row = pair_row(left);
            act = row[8*(CLASS_COUNT-1-right) +: 8];
            if (act == "D" || (act == "I" && lb_after_space))
                r.seg_start = 1'b1;
            lb_cur_class = code[CLASS_W-1:0];
            lb_after_space = 1'b0;
            r.byte_class = code[CLASS_W-1:0];
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic add_byte(input logic [7:0] b, input logic first);
        text_item_t item;
        item = '{drain: 1'b0, text_start: first, text_byte: b};
        pending_text = {pending_text, item};
    endtask

    task automatic add_drain();
        text_item_t item;
        item = '{drain: 1'b1, text_start: 1'b0, text_byte: 8'h00};
        pending_text = {pending_text, item};
    endtask

    // input side
    always @(negedge aclk) begin : drive_text
        logic nxt_valid;
        text_item_t head;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !in_fire)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_text.size() > 0) begin
                if (pending_text[0].drain) begin
                    if (expected_marks.size() == 0)
                        head = pending_text.pop_front();
                end else begin
                    head = pending_text.pop_front();
                    nxt_valid = 1'b1;
                    s_text_byte <= head.text_byte;
                    s_text_start <= head.text_start;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(20, 80);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left = $urandom_range(1, 6);
                        end
                    end
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin : drive_ready
        logic nxt_ready;
        if (ready_span == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_span = $urandom_range(32, 256);
            ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
            stall_left = 0;
        end else begin
            ready_span--;
        end
        case (ready_mode)
            RDY_ALWAYS:  nxt_ready = 1'b1;
            RDY_RANDOM:  nxt_ready = ($urandom_range(0, 3) != 0);
            RDY_PATTERN: begin
                nxt_ready = ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    nxt_ready = 1'b0;
                end else begin
                    nxt_ready = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(5, 30);
                end
            end
        endcase
        m_ready <= nxt_ready;
    end

    always @(posedge aclk) begin : watch
        lbof_result_t got;
        lbof_result_t want;
        cycle_count <= cycle_count + 1;
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_marks = {expected_marks, predict_marks(s_text_byte, s_text_start)};
        if (aresetn && m_valid && m_ready) begin
            got.seg_start = m_segment_start;
            got.seg_closed = m_segment_closed;
            got.byte_class = m_byte_class;
            if (expected_marks.size() == 0) begin
                log_mismatch($sformatf("unexpected transfer start=%b closed=%b class=%0d",
                    got.seg_start, got.seg_closed, got.byte_class));
            end else begin
                want = expected_marks.pop_front();
                if (got.seg_start !== want.seg_start || got.seg_closed !== want.seg_closed
                        || got.byte_class !== want.byte_class)
                    log_mismatch($sformatf(
                        "expected start=%b closed=%b class=%0d, got start=%b closed=%b class=%0d",
                        want.seg_start, want.seg_closed, want.byte_class,
                        got.seg_start, got.seg_closed, got.byte_class));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
            @(posedge aclk);
        $display("line_break_opportunity_finder regression: fail");
        $finish;
    end

    initial begin : run
        int unsigned n_random;
        int unsigned len;
        int unsigned r;
        logic [7:0] b;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_text_byte = 8'h00;
        s_text_start = 1'b0;
        m_ready = 1'b0;

        // directed
        add_byte("A", 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(" ", 1'b0);
        add_byte("\"", 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(CR_BYTE, 1'b0);
        add_byte(NEWLINE_BYTE, 1'b0);
        add_byte(" ", 1'b0);
        add_byte("a", 1'b0);
        add_byte(VT_BYTE, 1'b0);
        add_byte(FF_BYTE, 1'b0);
        add_byte("(", 1'b1);
        add_byte(")", 1'b0);
        add_byte("9", 1'b0);
        add_byte("%", 1'b0);
        add_byte("-", 1'b0);
        add_byte(DEL_BYTE, 1'b0);
        add_byte("}", 1'b0);
        add_byte(TAB_BYTE, 1'b0);
        add_byte("\\", 1'b0);
        add_byte(NEWLINE_BYTE, 1'b1);
        add_byte("!", 1'b1);
        add_byte(8'h7e, 1'b0);
        add_drain();

        // random texts, with some noise
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 40);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        b = $urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                                 : 8'($urandom_range(65, 90));
                    else if (r < 55)
                        b = 8'($urandom_range(48, 57));
                    else if (r < 70)
                        b = " ";
                    else if (r < 85)
                        b = PUNCT[8*$urandom_range(0, 30) +: 8];
                    else if (r < 90)
                        b = 8'($urandom_range(9, 13));
                    else if (r < 95)
                        b = 8'($urandom_range(128, 255));
                    else
                        b = 8'($urandom_range(0, 255));
                    add_byte(b, k == 0);
                end
            end else begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            n_random += len;
            if ($urandom_range(0, 39) == 0)
                add_drain();
        end

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_text.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_marks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("line_break_opportunity_finder regression: pass");
        else
            $display("line_break_opportunity_finder regression: fail");
        $finish;
    end

endmodule

// File: line_break_opportunity_finder.f
src/lbof_pkg.sv
src/lbof_classify.sv
src/lbof_step.sv
src/line_break_opportunity_finder.sv
src/lbof_checker.sv
bench/line_break_opportunity_finder_tb.sv
